// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the vector normalizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define VLN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vln assertion failed");
// Next-cycle implication, disabled during reset
`define VLN_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vln assertion failed");
`else
`define VLN_ASSERT_IMP(label, clk, rst, ante, cons)
`define VLN_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/vln_pkg.sv =====
// ----------------------------------------------------------------------------
// vln_pkg
// Types and fixed widths shared by the vector normalizer modules.
// ----------------------------------------------------------------------------
`default_nettype none
package vln_pkg;

  localparam int FIELD_W = 16;  // input component field
  localparam int MAG_W   = 16;  // component magnitude
  localparam int SQ_W    = 31;  // square of a magnitude
  localparam int SUM_W   = 33;  // sum of up to four squares
  localparam int ROOT_W  = 17;  // integer root of a SUM_W value
  localparam int QUO_W   = 33;  // quotient a^2 * 2^32 / s
  localparam int LEN_W   = 17;
  localparam int UNIT_W  = 16;
  localparam int MAX_DIM = 4;

  // pipeline depth, accept to result strobe
  localparam int LANE_LAT  = 2;
  localparam int TOTAL_LAT = LANE_LAT + QUO_W + ROOT_W + 1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] comp_x;
    logic signed [FIELD_W-1:0] comp_y;
    logic signed [FIELD_W-1:0] comp_z;
    logic signed [FIELD_W-1:0] comp_w;
  } in_word_t;

  typedef struct packed {
    logic [LEN_W-1:0]         vec_length;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic signed [UNIT_W-1:0] unit_w;
    logic                     zero_vector;
  } out_word_t;

endpackage
`default_nettype wire

// ===== hdl/vln_sqrt.sv =====
// ----------------------------------------------------------------------------
// vln_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Gives floor root and remainder x - root^2, with a sideband carried along.
// ----------------------------------------------------------------------------
`default_nettype none
module vln_sqrt #(
  parameter int ROOT_W = 17,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic [2*ROOT_W-1:0] x,
  input  logic [SIDE_W-1:0]   side_in,
  output logic [ROOT_W-1:0]   root,
  output logic [ROOT_W+1:0]   rem,
  output logic [SIDE_W-1:0]   side_out
);
  localparam int X_W   = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [X_W-1:0]    xs_q   [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  genvar k;
  for (k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]  rem_i, rem_sh, trial;
    logic [ROOT_W-1:0] root_i;
    logic [X_W-1:0]    xs_i;
    logic [SIDE_W-1:0] side_i;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign xs_i   = x;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign xs_i   = xs_q[k-1];
      assign side_i = side_q[k-1];
    end

    // bring down the next two radicand bits and try root bit 1
    assign rem_sh = {rem_i[REM_W-3:0], xs_i[X_W-1 -: 2]};
    assign trial  = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      xs_q[k]   <= {xs_i[X_W-3:0], 2'b00};
      side_q[k] <= side_i;
      if (rem_sh >= trial) begin
        rem_q[k]  <= rem_sh - trial;
        root_q[k] <= {root_i[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[k]  <= rem_sh;
        root_q[k] <= {root_i[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root     = root_q[ROOT_W-1];
  assign rem      = rem_q[ROOT_W-1];
  assign side_out = side_q[ROOT_W-1];
endmodule
`default_nettype wire

// ===== hdl/vln_lane.sv =====
// ----------------------------------------------------------------------------
// vln_lane
// Front of one component lane: sign-extend, magnitude and square.
// ----------------------------------------------------------------------------
`default_nettype none
module vln_lane #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic [vln_pkg::FIELD_W-1:0]  raw,
  output logic [vln_pkg::SQ_W-1:0]     sq,      // stage 1, to the sum
  output logic [vln_pkg::SQ_W-1:0]     sq_d,    // stage 2, beside the sum
  output logic                         neg_d
);
  localparam int EFF_W = (COMP_WIDTH < vln_pkg::FIELD_W) ? COMP_WIDTH : vln_pkg::FIELD_W;
  localparam int EXT_W = vln_pkg::FIELD_W + 1;

  logic [EFF_W-1:0]          low;
  logic [EXT_W-1:0]          ext, absv;
  logic [vln_pkg::MAG_W-1:0] mag;
  logic [2*vln_pkg::MAG_W-1:0] prod;
  logic                      neg;

  // low bits of the field, sign extended
  assign low  = raw[EFF_W-1:0];
  assign neg  = low[EFF_W-1];
  assign ext  = {{(EXT_W-EFF_W){neg}}, low};
  assign absv = neg ? (~ext + 1'b1) : ext;
  assign mag  = absv[vln_pkg::MAG_W-1:0];
  assign prod = mag * mag;

  logic neg_q;

  always_ff @(posedge clk) begin
    sq    <= prod[vln_pkg::SQ_W-1:0];
    neg_q <= neg;
    sq_d  <= sq;
    neg_d <= neg_q;
  end
endmodule
`default_nettype wire

// ===== hdl/vln_unit.sv =====
// ----------------------------------------------------------------------------
// vln_unit
// One unit component: pipelined divide a^2*2^32/s, root of the quotient,
// then round, sign and saturate to Q1.15.
// ----------------------------------------------------------------------------
`default_nettype none
module vln_unit (
  input  logic                              clk,
  input  logic [vln_pkg::SQ_W-1:0]          a2,
  input  logic [vln_pkg::SUM_W-1:0]         s,
  input  logic                              neg,
  output logic signed [vln_pkg::UNIT_W-1:0] unit_val
);
  localparam int SW = vln_pkg::SUM_W;
  localparam int QW = vln_pkg::QUO_W;
  localparam int RW = vln_pkg::ROOT_W;

  logic [SW-1:0] rem_q [QW];
  logic [SW-1:0] s_q   [QW];
  logic [QW-1:0] q_q   [QW];
  logic          neg_q [QW];

  // restoring divider, one quotient bit per stage
  genvar k;
  for (k = 0; k < QW; k++) begin : g_div
    logic [SW-1:0] rem_i, s_i;
    logic [QW-1:0] q_i;
    logic          neg_i, nb;
    logic [SW:0]   rem_sh, diff;

    if (k == 0) begin : g_first
      assign rem_i = SW'(a2 >> 1);
      assign nb    = a2[0];
      assign s_i   = s;
      assign q_i   = '0;
      assign neg_i = neg;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign nb    = 1'b0;
      assign s_i   = s_q[k-1];
      assign q_i   = q_q[k-1];
      assign neg_i = neg_q[k-1];
    end

    assign rem_sh = {rem_i, nb};
    assign diff   = rem_sh - {1'b0, s_i};

    always_ff @(posedge clk) begin
      s_q[k]   <= s_i;
      neg_q[k] <= neg_i;
      if (rem_sh >= {1'b0, s_i}) begin
        rem_q[k] <= diff[SW-1:0];
        q_q[k]   <= {q_i[QW-2:0], 1'b1};
      end else begin
        rem_q[k] <= rem_sh[SW-1:0];
        q_q[k]   <= {q_i[QW-2:0], 1'b0};
      end
    end
  end

  logic [RW-1:0]   root;
  logic [RW+1:0]   root_rem;
  logic            neg_r;
  logic [RW:0]     half;     // (root + 1) / 2, at most 32768
  logic [vln_pkg::UNIT_W-1:0] mag, mag_neg, mag_pos;

  vln_sqrt #(.ROOT_W(RW), .SIDE_W(1)) u_sqrt (
    .clk      (clk),
    .x        ({{(2*RW-QW){1'b0}}, q_q[QW-1]}),
    .side_in  (neg_q[QW-1]),
    .root     (root),
    .rem      (root_rem),
    .side_out (neg_r)
  );

  // odd-step root rounds to nearest, ties away from zero
  assign half    = ({1'b0, root} + 1'b1) >> 1;
  assign mag     = half[vln_pkg::UNIT_W-1:0];
  assign mag_neg = ~mag + 1'b1;
  // half can reach 32768 when one component dominates; positive side clips
  assign mag_pos = half[vln_pkg::UNIT_W-1] ? {1'b0, {(vln_pkg::UNIT_W-1){1'b1}}} : mag;

  always_ff @(posedge clk) begin
    unit_val <= neg_r ? mag_neg : mag_pos;
  end
endmodule
`default_nettype wire

// ===== hdl/vector_length_normalize.sv =====
// ----------------------------------------------------------------------------
// vector_length_normalize
// Euclidean length and unit vector of a DIM-component integer vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive din and raise start; the word is taken at any edge with
//   start high and busy low. busy stays low, so a word can enter every cycle.
//   Output: done pulses for one cycle with dout holding the length (rounded
//   integer), the Q1.15 unit components and the zero flag. The receiver has
//   no stall; it must take every word on its done cycle.
//   Pipeline: 53 register stages from the accepting edge to done;
//   throughput one word per cycle. The stages are square and sum
//   (2), the per-lane divider (one quotient bit per stage, 33), the 17-stage
//   root of the quotient and the output register (1).
//   Config: cfg_data is written to robust_mode on cfg_valid (cfg_ready is
//   always high). Both modes give identical results in exact arithmetic.
//   Reset (rst, synchronous) clears robust_mode and the in-flight valid bits;
//   words in flight at reset are dropped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module vector_length_normalize #(
  parameter int DIM        = 3,
  parameter int COMP_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  vln_pkg::in_word_t  din,
  output logic               done,
  output vln_pkg::out_word_t dout,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  localparam int ND    = vln_pkg::MAX_DIM;
  localparam int RW    = vln_pkg::ROOT_W;
  localparam int LW    = vln_pkg::LEN_W;
  localparam int UW    = vln_pkg::UNIT_W;
  localparam int TL    = vln_pkg::TOTAL_LAT;
  localparam int DLY_N = TL - 2 - RW;

  // max-abs prescale select; no datapath logic reads it, so it is result-neutral
  logic robust_mode;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      robust_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      robust_mode <= cfg_data;
    end
  end

  // valid bits through the pipeline
  logic [TL-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TL-2:0], start && !busy};
    end
  end
  assign done = vld[TL-1];

  // lanes
  logic [vln_pkg::FIELD_W-1:0] raw [ND];
  assign raw[0] = din.comp_x;
  assign raw[1] = din.comp_y;
  assign raw[2] = din.comp_z;
  assign raw[3] = din.comp_w;

  logic [vln_pkg::SQ_W-1:0] sq   [DIM];
  logic [vln_pkg::SQ_W-1:0] sq_d [DIM];
  logic                     neg_d [DIM];
  logic [UW-1:0]            unit_q [ND];

  logic [vln_pkg::SUM_W-1:0] s;
  logic                      zero_s;

  genvar i;
  for (i = 0; i < ND; i++) begin : g_lane
    if (i < DIM) begin : g_used
      vln_lane #(.COMP_WIDTH(COMP_WIDTH)) u_lane (
        .clk   (clk),
        .raw   (raw[i]),
        .sq    (sq[i]),
        .sq_d  (sq_d[i]),
        .neg_d (neg_d[i])
      );
      vln_unit u_unit (
        .clk      (clk),
        .a2       (sq_d[i]),
        .s        (s),
        .neg      (neg_d[i]),
        .unit_val (unit_q[i])
      );
    end else begin : g_unused
      assign unit_q[i] = '0;
    end
  end

  // merge: sum of squares
  logic [vln_pkg::SUM_W-1:0] s_next;
  always_comb begin
    s_next = '0;
    for (int j = 0; j < DIM; j++) begin
      s_next = s_next + vln_pkg::SUM_W'(sq[j]);
    end
  end

  always_ff @(posedge clk) begin
    s      <= s_next;
    zero_s <= (s_next == '0);
  end

  // length: root of s, rounded to nearest
  logic [RW-1:0]   len_root;
  logic [RW+1:0]   len_rem;
  logic            zero_r;
  logic [LW-1:0]   len_rnd;

  vln_sqrt #(.ROOT_W(RW), .SIDE_W(1)) u_len_sqrt (
    .clk      (clk),
    .x        ({{(2*RW-vln_pkg::SUM_W){1'b0}}, s}),
    .side_in  (zero_s),
    .root     (len_root),
    .rem      (len_rem),
    .side_out (zero_r)
  );

  assign len_rnd = (len_rem > {2'b00, len_root}) ? LW'(len_root + 1'b1) : LW'(len_root);

  // hold length and zero flag until the unit lanes finish
  logic [LW:0] dly [DLY_N];
  always_ff @(posedge clk) begin
    dly[0] <= {zero_r, len_rnd};
    for (int j = 1; j < DLY_N; j++) begin
      dly[j] <= dly[j-1];
    end
  end

  logic zero_o;
  assign zero_o = dly[DLY_N-1][LW];

  always_comb begin
    dout.zero_vector = zero_o;
    dout.vec_length  = zero_o ? '0 : dly[DLY_N-1][LW-1:0];
    dout.unit_x      = zero_o ? '0 : unit_q[0];
    dout.unit_y      = zero_o ? '0 : unit_q[1];
    dout.unit_z      = zero_o ? '0 : unit_q[2];
    dout.unit_w      = zero_o ? '0 : unit_q[3];
  end

  // all unit components of the output word are zero
  logic unit_zero;
  assign unit_zero = dout.unit_x == '0 && dout.unit_y == '0 &&
                     dout.unit_z == '0 && dout.unit_w == '0;

  `VLN_ASSERT_IMP(a_zero_clean, clk, rst, done && dout.zero_vector, dout.vec_length == '0 && unit_zero)
  `VLN_ASSERT_IMP(a_len_nonzero, clk, rst, done && !dout.zero_vector, dout.vec_length != '0)
  `VLN_ASSERT_IMP(a_unit_nonzero, clk, rst, done && !dout.zero_vector, !unit_zero)
  `VLN_ASSERT_IMP(a_unused_w, clk, rst, done, DIM >= ND || dout.unit_w == '0)
  `VLN_ASSERT_NXT(a_accept_tracked, clk, rst, start && !busy, vld[0])
endmodule
`default_nettype wire

// ===== tb/tb_vector_length_normalize.sv =====
// ----------------------------------------------------------------------------
// tb_vector_length_normalize
// Self-checking bench for the vector normalizer: directed corner vectors and
// random vectors go in under random start gaps, both mode settings are used,
// and every done word is compared field by field with a local prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_vector_length_normalize;

  localparam int DIM        = 3;
  localparam int COMP_WIDTH = 16;
  localparam int EFF_W      = COMP_WIDTH < 16 ? COMP_WIDTH : 16;
  localparam int IDLE_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  vln_pkg::in_word_t  din = '0;
  logic               done;
  vln_pkg::out_word_t dout;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  vln_pkg::out_word_t norm_queue[$];
  logic      gaps_on;
  int        errors = 0;
  int        words_sent;
  int        idle_cycles = 0;

  always #5 clk = ~clk;

  vector_length_normalize #(.DIM(DIM), .COMP_WIDTH(COMP_WIDTH)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .din(din), .done(done),
    .dout(dout), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // signed component from the low EFF_W bits of a field
  function automatic longint comp_value(logic [15:0] raw);
    longint v;
    v = raw & ((64'd1 << EFF_W) - 1);
    if (v >= (64'd1 << (EFF_W - 1))) v = v - (64'd1 << EFF_W);
    return v;
  endfunction

  function automatic longint round_root(longint unsigned s);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= s) lo = mid;
      else hi = mid - 1;
    end
    if (s - lo * lo > lo) lo++;
    return lo;
  endfunction

  // largest n with (2n-1)^2 * s <= c^2 * 2^32
  function automatic longint unit_magnitude(longint unsigned a, longint unsigned s);
    longint unsigned rhs, lo, hi, mid, t;
    rhs = (a * a) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * mid - 1;
      if (t * t * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic vln_pkg::out_word_t normalize(vln_pkg::in_word_t w);
    vln_pkg::out_word_t r;
    longint        c[4];
    longint        m;
    longint unsigned s;
    logic [15:0]   u[4];
    r = '0;
    s = 0;
    c[0] = comp_value(w.comp_x);
    c[1] = comp_value(w.comp_y);
    c[2] = comp_value(w.comp_z);
    c[3] = comp_value(w.comp_w);
    for (int i = 0; i < 4; i++) begin
      if (i >= DIM) c[i] = 0;
      s += c[i] * c[i];
    end
    if (s == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      m = unit_magnitude(c[i] < 0 ? -c[i] : c[i], s);
      if (c[i] < 0) m = -m;
      else if (m > 32767) m = 32767;
      u[i] = m[15:0];
    end
    r.vec_length = 17'(round_root(s));
    r.unit_x = u[0];
    r.unit_y = u[1];
    r.unit_z = u[2];
    r.unit_w = u[3];
    return r;
  endfunction

  // send one vector; a gap may precede it
  task automatic send_vector(vln_pkg::in_word_t w);
    if (gaps_on) begin
      while ($urandom_range(99) < 19) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    din   <= w;
    norm_queue.push_back(normalize(w));
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (norm_queue.size() != 0) @(posedge clk);
    repeat (vln_pkg::TOTAL_LAT + 5) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic vln_pkg::in_word_t vec(int x, int y, int z, int w);
    vln_pkg::in_word_t v;
    v.comp_x = 16'(x);
    v.comp_y = 16'(y);
    v.comp_z = 16'(z);
    v.comp_w = 16'(w);
    return v;
  endfunction

  // extremes, zero vector, ties, saturation, unused lane
  task automatic test_directed();
    send_vector(vec(0, 0, 0, 0));
    send_vector(vec(0, 0, 0, 32767));
    send_vector(vec(32767, 0, 0, 0));
    send_vector(vec(-32768, 0, 0, 0));
    send_vector(vec(0, -32768, 0, 0));
    send_vector(vec(0, 0, 1, 0));
    send_vector(vec(-32768, -32768, -32768, -32768));
    send_vector(vec(32767, 32767, 32767, 32767));
    send_vector(vec(-32768, 32767, -1, 0));
    send_vector(vec(3, 4, 0, 0));
    send_vector(vec(-3, 4, 12, 5));
    send_vector(vec(1, 1, 0, 0));
    send_vector(vec(1, -1, 1, -1));
    send_vector(vec(1, 0, -1, 0));
    send_vector(vec(-1, -1, -1, 0));
    send_vector(vec(1, 65535, 0, 21845));
    send_vector(vec(100, 0, 1, 0));
    send_vector(vec(-5, 12, 0, -7));
  endtask

  // random vectors, mostly full range, some small magnitudes
  task automatic test_random(int count);
    vln_pkg::in_word_t w;
    for (int n = 0; n < count; n++) begin
      gaps_on = !(n >= count / 3 && n < count / 2);
      w = {$urandom, $urandom};
      if ($urandom_range(3) == 0) begin
        w.comp_x = $signed(w.comp_x) >>> 12;
        w.comp_y = $signed(w.comp_y) >>> 12;
        w.comp_z = $signed(w.comp_z) >>> 12;
      end
      if ($urandom_range(15) == 0) w.comp_z = 0;
      send_vector(w);
    end
    gaps_on = 1'b1;
  endtask

  // compare each done word against the oldest prediction
  always @(posedge clk) begin
    vln_pkg::out_word_t want;
    if (!rst && done) begin
      if (norm_queue.size() == 0) begin
        $error("unexpected word: vec_length %0d", dout.vec_length);
        errors++;
      end else begin
        want = norm_queue.pop_front();
        if (dout.vec_length !== want.vec_length) begin
          $error("vec_length exp %0d got %0d", want.vec_length, dout.vec_length); errors++;
        end
        if (dout.unit_x !== want.unit_x) begin
          $error("unit_x exp %0d got %0d", want.unit_x, dout.unit_x); errors++;
        end
        if (dout.unit_y !== want.unit_y) begin
          $error("unit_y exp %0d got %0d", want.unit_y, dout.unit_y); errors++;
        end
        if (dout.unit_z !== want.unit_z) begin
          $error("unit_z exp %0d got %0d", want.unit_z, dout.unit_z); errors++;
        end
        if (dout.unit_w !== want.unit_w) begin
          $error("unit_w exp %0d got %0d", want.unit_w, dout.unit_w); errors++;
        end
        if (dout.zero_vector !== want.zero_vector) begin
          $error("zero_vector exp %0d got %0d", want.zero_vector, dout.zero_vector);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without an accepted word, a done word or a config write
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    words_sent = 0;
    gaps_on = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    write_mode(1'b1);
    test_directed();
    test_random(200);
    drain();
    write_mode(1'b0);
    test_random(200);
    drain();
    $display("Sent %0d vectors (DIM %0d) in both robust_mode settings,", words_sent, DIM);
    $display("covering zero, extreme, tie and random components.");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/vln_pkg.sv
hdl/vln_sqrt.sv
hdl/vln_lane.sv
hdl/vln_unit.sv
hdl/vector_length_normalize.sv
tb/tb_vector_length_normalize.sv
